FILE: src/stk_pkg.sv
// Shared types and codes for the LIFO stack engine.
// No dependencies; imported by the top level, stk_div10 and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package stk_pkg;

  // request codes
  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_REVERSE = 3'd2,
    OP_DELETE  = 3'd3,
    OP_DIGITS  = 3'd4,
    OP_FOLD    = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_PUSH,
    S_POP_RD,
    S_POP_WB,
    S_REV_RLO,
    S_REV_RHI,
    S_REV_WLO,
    S_REV_WHI,
    S_DEL_RD,
    S_DEL_CHK,
    S_DIG_MUL,
    S_DIG_SUB,
    S_DIG_PUSH,
    S_FOLD_RD,
    S_FOLD_ACC,
    S_TOP_RD,
    S_RESP
  } state_e;

  localparam int unsigned MaxDigits = 10;
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] even_sum;
  } rsp_t;

endpackage
`default_nettype wire

FILE: src/stack_engine_with_digit_ops.sv
// Top level of the LIFO stack engine: sequencer and datapath.
// Uses stk_pkg, stk_mem and stk_div10.
//
//  channel   | ports                 | handshake
//  ----------+-----------------------+-----------------------------
//  request   | req_i                 | taken when start & !busy
//  result    | rsp_o                 | valid one cycle with done_o
//
// Push writes the word in S_PUSH; pop reads the top entry, then writes back
// the fill level. Reverse reads both ends and writes both ends for each swapped
// pair, delete reads and checks each held entry, pop-as-number reads and adds
// each held entry, digit push multiplies and subtracts for each digit to split
// and then stores the digits one at a time; each walk ends with a top read and
// a result state. All walks go through the single port pair of the word store.
// Reset clears fill level, even sum and the sequencer; the store needs no
// clearing. busy stays high through the done_o cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module stack_engine_with_digit_ops #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  stk_pkg::req_t  req_i,
  output logic           done_o,
  output stk_pkg::rsp_t  rsp_o
);
  import stk_pkg::*;

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  state_e         state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, kept_q, kept_d;
  logic [31:0]    even_q, even_d;
  logic [31:0]    val_q, val_d;
  logic [31:0]    res_q, res_d;
  logic [31:0]    tmp_q, tmp_d;
  status_e        status_q, status_d;
  op_e            op_q, op_d;
  logic [3:0]     nd_q, nd_d;
  logic [3:0]     dig_q [MaxDigits];
  logic [3:0]     dig_d [MaxDigits];

  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]     wdata, rdata, quot, q_times10, fold_next;
  logic [3:0]      digit;
  logic [3:0]      dig_top;
  logic [31:0]     fit_need, cnt32;
  logic            accept;

  stk_mem #(.Depth(STACK_DEPTH), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stk_div10 u_div (
    .clk_i (clk_i),
    .n_i   (val_q),
    .q_o   (quot)
  );

  assign accept    = start && !busy;
  assign q_times10 = (quot << 3) + (quot << 1);
  assign digit     = 4'(val_q - q_times10);
  assign fold_next = (res_q << 3) + (res_q << 1) + rdata;
  assign fit_need  = 32'(fill_q) + 32'(nd_q) + 32'd1;
  assign dig_top   = dig_q[nd_q - 4'd1];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            OP_PUSH:    state_d = S_PUSH;
            OP_POP:     state_d = (fill_q == '0) ? S_TOP_RD : S_POP_RD;
            OP_REVERSE: state_d = (fill_q > CntW'(1)) ? S_REV_RLO : S_TOP_RD;
            OP_DELETE:  state_d = (fill_q == '0) ? S_TOP_RD : S_DEL_RD;
            OP_DIGITS:  state_d = (!req_i.value[31] && req_i.value != 0) ? S_DIG_MUL
                                                                           : S_TOP_RD;
            OP_FOLD:    state_d = (fill_q == '0) ? S_TOP_RD : S_FOLD_RD;
            default:    state_d = S_TOP_RD;
          endcase
        end
      end
      S_PUSH:     state_d = S_TOP_RD;
      S_POP_RD:   state_d = S_POP_WB;
      S_POP_WB:   state_d = S_TOP_RD;
      S_REV_RLO:  state_d = S_REV_RHI;
      S_REV_RHI:  state_d = S_REV_WLO;
      S_REV_WLO:  state_d = S_REV_WHI;
      S_REV_WHI:  state_d = (lo_q + CntW'(1) < hi_q - CntW'(1)) ? S_REV_RLO : S_TOP_RD;
      S_DEL_RD:   state_d = S_DEL_CHK;
      S_DEL_CHK:  state_d = (lo_q + CntW'(1) == fill_q) ? S_TOP_RD : S_DEL_RD;
      S_DIG_MUL:  state_d = S_DIG_SUB;
      S_DIG_SUB: begin
        if (quot != 0) begin
          state_d = S_DIG_MUL;
        end else if (fit_need > 32'(STACK_DEPTH)) begin
          state_d = S_TOP_RD;
        end else begin
          state_d = S_DIG_PUSH;
        end
      end
      S_DIG_PUSH: state_d = (nd_q == 4'd1) ? S_TOP_RD : S_DIG_PUSH;
      S_FOLD_RD:  state_d = S_FOLD_ACC;
      S_FOLD_ACC: state_d = (lo_q + CntW'(1) == fill_q) ? S_TOP_RD : S_FOLD_RD;
      S_TOP_RD:   state_d = S_RESP;
      S_RESP:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    fill_d   = fill_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    kept_d   = kept_q;
    even_d   = even_q;
    val_d    = val_q;
    res_d    = res_q;
    tmp_d    = tmp_q;
    status_d = status_q;
    op_d     = op_q;
    nd_d     = nd_q;
    dig_d    = dig_q;
    we       = 1'b0;
    waddr    = fill_q[AddrW-1:0];
    wdata    = val_q;
    raddr    = lo_q[AddrW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = op_e'(req_i.req_type);
          val_d    = req_i.value;
          res_d    = '0;
          status_d = ST_OK;
          lo_d     = '0;
          hi_d     = fill_q - CntW'(1);
          kept_d   = '0;
          nd_d     = '0;
          if (req_i.req_type == OP_POP && fill_q == '0) begin
            res_d    = '1;
            status_d = ST_EMPTY;
          end
          if (req_i.req_type == OP_DELETE) begin
            even_d = '0;
          end
        end
      end
      S_PUSH: begin
        if (fill_q >= CntW'(STACK_DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          we     = 1'b1;
          fill_d = fill_q + CntW'(1);
          if (!val_q[0]) even_d = even_q + val_q;
        end
      end
      S_POP_RD: raddr = hi_q[AddrW-1:0];
      S_POP_WB: begin
        res_d  = rdata;
        fill_d = fill_q - CntW'(1);
        if (!rdata[0]) even_d = even_q - rdata;
      end
      S_REV_RLO: raddr = lo_q[AddrW-1:0];
      S_REV_RHI: begin
        raddr = hi_q[AddrW-1:0];
        tmp_d = rdata;
      end
      S_REV_WLO: begin
        we    = 1'b1;
        waddr = lo_q[AddrW-1:0];
        wdata = rdata;
      end
      S_REV_WHI: begin
        we    = 1'b1;
        waddr = hi_q[AddrW-1:0];
        wdata = tmp_q;
        lo_d  = lo_q + CntW'(1);
        hi_d  = hi_q - CntW'(1);
      end
      S_DEL_RD: raddr = lo_q[AddrW-1:0];
      S_DEL_CHK: begin
        if (rdata != val_q) begin
          we     = 1'b1;
          waddr  = kept_q[AddrW-1:0];
          wdata  = rdata;
          kept_d = kept_q + CntW'(1);
          if (!rdata[0]) even_d = even_q + rdata;
        end
        lo_d = lo_q + CntW'(1);
        if (lo_q + CntW'(1) == fill_q) begin
          fill_d = (rdata != val_q) ? kept_q + CntW'(1) : kept_q;
        end
      end
      S_DIG_MUL: ;
      S_DIG_SUB: begin
        // store digits least significant first
        dig_d[nd_q] = digit;
        nd_d        = nd_q + 4'd1;
        val_d       = quot;
        if (quot == 0 && fit_need > 32'(STACK_DEPTH)) status_d = ST_FULL;
      end
      S_DIG_PUSH: begin
        // dig_q[nd_q-1] holds the most significant digit still to push
        we     = 1'b1;
        wdata  = {28'd0, dig_top};
        fill_d = fill_q + CntW'(1);
        nd_d   = nd_q - 4'd1;
        if (!dig_top[0]) even_d = even_q + {28'd0, dig_top};
      end
      S_FOLD_RD: raddr = lo_q[AddrW-1:0];
      S_FOLD_ACC: begin
        res_d = fold_next;
        lo_d  = lo_q + CntW'(1);
        if (lo_q + CntW'(1) == fill_q) begin
          fill_d = '0;
          even_d = '0;
        end
      end
      S_TOP_RD: raddr = 32'(fill_q - CntW'(1)) < 32'(STACK_DEPTH)
                        ? AddrW'(fill_q - CntW'(1)) : '0;
      S_RESP:   raddr = AddrW'(fill_q - CntW'(1));
      default: ;
    endcase
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      even_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      even_q  <= even_d;
    end
  end

  // hold working registers
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    kept_q   <= kept_d;
    val_q    <= val_d;
    res_q    <= res_d;
    tmp_q    <= tmp_d;
    status_q <= status_d;
    op_q     <= op_d;
    nd_q     <= nd_d;
    dig_q    <= dig_d;
  end

  // drive handshake and result
  assign cnt32  = 32'(fill_q);
  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);
  always_comb begin
    rsp_o.result_value = res_q;
    rsp_o.status       = status_q;
    rsp_o.top_value    = (fill_q == '0) ? '1 : rdata;
    rsp_o.entry_count  = cnt32[6:0];
    rsp_o.is_empty     = (fill_q == '0);
    rsp_o.even_sum     = even_q;
  end

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(STACK_DEPTH)) else $error("fill level beyond depth");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(done_o)) else $error("busy dropped without result");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("request taken but not busy");
  a_full_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q == ST_FULL) |-> (op_q == OP_PUSH || op_q == OP_DIGITS))
    else $error("full status on a non-push request");

endmodule
`default_nettype wire

FILE: src/stk_mem.sv
// Stack word store: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module stk_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AddrW-1:0]  waddr_i,
  input  wire [31:0]       wdata_i,
  input  wire [AddrW-1:0]  raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem [Depth];

  // write and read the array, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: src/stk_div10.sv
// Divide-by-ten unit: reciprocal multiply, product registered.
// Uses Recip10 from stk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stk_div10 (
  input  wire         clk_i,
  input  wire  [31:0] n_i,
  output logic [31:0] q_o
);
  import stk_pkg::*;

  logic [63:0] prod_q;

  // register the reciprocal product
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(n_i) * 64'(Recip10);
  end

  // quotient is the product shifted down by 35
  assign q_o = {3'b000, prod_q[63:35]};

endmodule
`default_nettype wire

FILE: sim/tb_stack_engine_with_digit_ops.sv
// Testbench for the LIFO stack engine: directed and random requests checked
// against a behavioral stack model. Depends on stk_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_stack_engine_with_digit_ops;
  import stk_pkg::*;

  localparam int Depth = 64;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  req_t  req_i = '0;
  logic  done_o;
  rsp_t  rsp_o;

  stack_engine_with_digit_ops #(.STACK_DEPTH(Depth)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // model state
  logic [31:0] model_words [Depth];
  int          model_fill;
  logic [31:0] model_even;
  rsp_t        expected_rsps [$];
  int          error_count;
  int          rsp_count;
  int          sent_count;

  // compute expected result of one request and advance the model
  function automatic rsp_t predict_stack(logic [2:0] op, logic [31:0] val);
    rsp_t r;
    int kept;
    int nd;
    logic [31:0] n;
    logic [31:0] t;
    logic [31:0] digs [10];
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (model_fill >= Depth) r.status = ST_FULL;
        else begin
          model_words[model_fill] = val;
          model_fill++;
          if (!val[0]) model_even += val;
        end
      end
      OP_POP: begin
        if (model_fill == 0) begin
          r.result_value = -1;
          r.status = ST_EMPTY;
        end else begin
          model_fill--;
          r.result_value = model_words[model_fill];
          if (!model_words[model_fill][0]) model_even -= model_words[model_fill];
        end
      end
      OP_REVERSE: begin
        for (int k = 0; k < model_fill / 2; k++) begin
          t = model_words[k];
          model_words[k] = model_words[model_fill - 1 - k];
          model_words[model_fill - 1 - k] = t;
        end
      end
      OP_DELETE: begin
        kept = 0;
        for (int k = 0; k < model_fill; k++)
          if (model_words[k] != val) begin
            model_words[kept] = model_words[k];
            kept++;
          end
        model_fill = kept;
        model_even = '0;
        for (int k = 0; k < model_fill; k++)
          if (!model_words[k][0]) model_even += model_words[k];
      end
      OP_DIGITS: begin
        if (!val[31] && val != 0) begin
          nd = 0;
          n = val;
          while (n > 0) begin
            digs[nd] = n % 10;
            nd++;
            n = n / 10;
          end
          if (model_fill + nd > Depth) r.status = ST_FULL;
          else begin
            while (nd > 0) begin
              nd--;
              model_words[model_fill] = digs[nd];
              model_fill++;
              if (!digs[nd][0]) model_even += digs[nd];
            end
          end
        end
      end
      OP_FOLD: begin
        n = '0;
        for (int k = 0; k < model_fill; k++) n = n * 10 + model_words[k];
        r.result_value = n;
        model_fill = 0;
        model_even = '0;
      end
      default: ;
    endcase
    r.top_value = (model_fill == 0) ? -1 : model_words[model_fill - 1];
    r.entry_count = 7'(model_fill);
    r.is_empty = (model_fill == 0);
    r.even_sum = model_even;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h expected %0h (result %0d)", what, got, want,
             rsp_count);
    error_count++;
  endtask

  // check each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    rsp_t w;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $display("unexpected result %0d", rsp_count);
        error_count++;
      end else begin
        w = expected_rsps.pop_front();
        if (rsp_o.result_value !== w.result_value)
          report_mismatch("result_value", rsp_o.result_value, w.result_value);
        if (rsp_o.status !== w.status) report_mismatch("status", rsp_o.status, w.status);
        if (rsp_o.top_value !== w.top_value)
          report_mismatch("top_value", rsp_o.top_value, w.top_value);
        if (rsp_o.entry_count !== w.entry_count)
          report_mismatch("entry_count", rsp_o.entry_count, w.entry_count);
        if (rsp_o.is_empty !== w.is_empty)
          report_mismatch("is_empty", rsp_o.is_empty, w.is_empty);
        if (rsp_o.even_sum !== w.even_sum)
          report_mismatch("even_sum", rsp_o.even_sum, w.even_sum);
      end
      rsp_count++;
    end
  end

  // sender bursts: remaining items in burst, then a gap
  int burst_left;

  // send one request and hold start until it is taken
  task automatic send_request(logic [2:0] op, logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= '{req_type: op, value: val};
    do @(posedge clk_i); while (busy);
    expected_rsps.push_back(predict_stack(op, val));
    sent_count++;
    start <= 1'b0;
    // let start drop before the next request drives it
    @(posedge clk_i);
  endtask

  task automatic test_basic_ops();
    send_request(OP_POP, 0);
    send_request(OP_FOLD, 0);
    send_request(OP_REVERSE, 0);
    send_request(OP_DELETE, 5);
    send_request(OP_PUSH, 32'h7FFF_FFFF);
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_PUSH, -2);
    send_request(OP_PUSH, 0);
    send_request(OP_REVERSE, 0);
    send_request(OP_DELETE, 0);
    send_request(OP_POP, 0);
    send_request(OP_DIGITS, 0);
    send_request(OP_DIGITS, -7);
    send_request(OP_DIGITS, 32'h7FFF_FFFF);
    send_request(OP_DIGITS, 9);
    send_request(3'd6, 1);
    send_request(3'd7, 1);
    send_request(OP_FOLD, 0);
    send_request(OP_POP, 0);
  endtask

  // fill to the top, overflow both push kinds, then drain
  task automatic test_full_stack();
    while (model_fill < Depth) send_request(OP_PUSH, $urandom());
    send_request(OP_PUSH, 1);
    send_request(OP_DIGITS, 5);
    send_request(OP_REVERSE, 0);
    send_request(OP_POP, 0);
    send_request(OP_DIGITS, 12);
    send_request(OP_POP, 0);
    send_request(OP_POP, 0);
    send_request(OP_DIGITS, 12);
    send_request(OP_FOLD, 0);
  endtask

  // random mix; small values so delete finds matches
  task automatic test_random_mix(int count);
    logic [2:0] op;
    logic [31:0] val;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_PUSH;
      else if (pick < 60) op = OP_POP;
      else if (pick < 68) op = OP_REVERSE;
      else if (pick < 78) op = OP_DELETE;
      else if (pick < 90) op = OP_DIGITS;
      else if (pick < 95) op = OP_FOLD;
      else op = 3'($urandom_range(6, 7));
      val = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12) : $urandom();
      if ($urandom_range(0, 9) == 0) val = -val;
      send_request(op, val);
    end
  endtask

  initial begin
    model_fill = 0;
    model_even = '0;
    error_count = 0;
    rsp_count = 0;
    sent_count = 0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_full_stack();
    test_random_mix(560);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results over all request codes",
             sent_count, rsp_count);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end
endmodule
